// ----- design/fpfa_pkg.sv -----
package fpfa_pkg;

    // Default number of partitions held by the allocator.
    localparam int PARTS_DEF = 8;

    // Field widths of the request and result channels.
    localparam int SIZE_W  = 16;
    localparam int INDEX_W = 3;
    localparam int MODE_W  = 2;
    localparam int COUNT_W = 4;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PART_COUNT = 1'd1;

    // Placement policies. The unused code behaves as first fit.
    localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

    // Request operations.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_ALLOC = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [MODE_W-1:0]  FIT_MODE_RST   = FIT_FIRST;
    localparam logic [COUNT_W-1:0] PART_COUNT_RST = 4'd8;

endpackage

// ----- design/fixed_partition_fit_allocator.sv -----
// Fixed-partition fit allocator. The block keeps the remaining size, in kilobytes, of
// PARTS memory partitions, all zero after reset. A load request sets one partition's
// size and answers with that partition and size; a load to an index at or above PARTS
// is refused. An allocate request scans the lowest min(partition_count, PARTS)
// partitions and picks the lowest-numbered one that fits (first fit, and the unused
// mode code), the smallest that fits (best fit) or the largest (worst fit), with ties
// going to the lowest partition number. The request size is subtracted from the chosen
// partition and the result carries granted, the partition number and the space left;
// when nothing fits the result is all zero and nothing changes. A request of size zero
// fits any partition. The sizes live in a small memory with one write port and one
// read port that one comparator walks through, one entry per cycle. After acceptance
// an allocate passes through the scan, update and done states, and a load goes
// straight to the done state; from the done state the result moves into a free output
// register, and the next request can be accepted once the block is back in idle. A
// result stall held on a full output register keeps the result in the done state.
// Only one request is in work at a time: o_stall stays high from acceptance until the
// result has moved into the output register, which then holds it until the receiver
// takes it. Configuration writes are taken at any time but must only be made while
// the block is idle.
module fixed_partition_fit_allocator #(
    parameter int PARTS = fpfa_pkg::PARTS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port.
    input  logic                                i_cfg_we,
    input  logic [fpfa_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fpfa_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // Request channel.
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_operation,
    input  logic [fpfa_pkg::INDEX_W-1:0]        i_partition_index,
    input  logic [fpfa_pkg::SIZE_W-1:0]         i_size_value,
    // Result channel.
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_granted,
    output logic [fpfa_pkg::INDEX_W-1:0]        o_partition_number,
    output logic [fpfa_pkg::SIZE_W-1:0]         o_space_left
);

    // Address width of the size memory, and the width of the scan counter, which must
    // hold both PARTS and the largest partition count.
    localparam int IDX_W = (PARTS > 1) ? $clog2(PARTS) : 1;
    localparam int CNT_W = $clog2(PARTS + 1);
    localparam int AW    = (CNT_W > fpfa_pkg::COUNT_W) ? CNT_W : fpfa_pkg::COUNT_W;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_UPDATE = 4'b0100,
        S_DONE   = 4'b1000
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [fpfa_pkg::MODE_W-1:0]  r_fit_mode;
    logic [fpfa_pkg::COUNT_W-1:0] r_part_count;

    // Partition size memory with one valid bit per entry; an entry that was never
    // written reads as zero.
    logic [fpfa_pkg::SIZE_W-1:0] r_mem [PARTS];
    logic [PARTS-1:0]            r_mem_valid;
    logic [fpfa_pkg::SIZE_W-1:0] r_rd_data;
    logic                        r_rd_live;

    // Scan state.
    logic [AW-1:0]               r_ptr;
    logic                        r_rdq_ok;
    logic [AW-1:0]               r_rdq_idx;
    logic                        r_found;
    logic [AW-1:0]               r_chosen;
    logic [fpfa_pkg::SIZE_W-1:0] r_best;
    logic [fpfa_pkg::SIZE_W-1:0] r_size;

    // Finished result waiting for the output register.
    logic                        r_res_granted;
    logic [fpfa_pkg::INDEX_W-1:0] r_res_part;
    logic [fpfa_pkg::SIZE_W-1:0] r_res_left;

    // Output register.
    logic                        r_out_valid;
    logic                        r_out_granted;
    logic [fpfa_pkg::INDEX_W-1:0] r_out_part;
    logic [fpfa_pkg::SIZE_W-1:0] r_out_left;

    logic                        accept;
    logic                        load_ok;
    logic [AW-1:0]               load_idx;
    logic [AW-1:0]               active;
    logic                        issue;
    logic [fpfa_pkg::SIZE_W-1:0] entry;
    logic                        fits;
    logic                        take;
    logic [fpfa_pkg::SIZE_W-1:0] new_left;
    logic                        out_free;

    logic                        w_we;
    logic [IDX_W-1:0]            w_addr;
    logic [fpfa_pkg::SIZE_W-1:0] w_data;
    logic [IDX_W-1:0]            rd_addr;

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && (r_state == S_IDLE);

    assign load_idx = AW'(i_partition_index);
    assign load_ok  = (load_idx < AW'(PARTS));

    // Allocation considers the lowest partition_count partitions, at most PARTS.
    assign active = (AW'(r_part_count) > AW'(PARTS)) ? AW'(PARTS) : AW'(r_part_count);
    assign issue  = (r_state == S_SCAN) && (r_ptr < active);

    // The shared compare unit: one fit test and one compare against the current pick.
    assign entry = r_rd_live ? r_rd_data : '0;
    assign fits  = r_rdq_ok && (r_size <= entry);
    assign take  = fits && (!r_found
                         || ((r_fit_mode == fpfa_pkg::FIT_BEST)  && (entry < r_best))
                         || ((r_fit_mode == fpfa_pkg::FIT_WORST) && (entry > r_best)));

    assign new_left = r_best - r_size;
    assign out_free = !r_out_valid || !i_stall;

    // One write port, shared by loads and by the update after a scan.
    always_comb begin
        w_we   = 1'b0;
        w_addr = load_idx[IDX_W-1:0];
        w_data = i_size_value;
        if (accept && (i_operation == fpfa_pkg::OP_LOAD) && load_ok) begin
            w_we = 1'b1;
        end else if ((r_state == S_UPDATE) && r_found) begin
            w_we   = 1'b1;
            w_addr = r_chosen[IDX_W-1:0];
            w_data = new_left;
        end
    end

    assign rd_addr = r_ptr[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= w_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode   <= fpfa_pkg::FIT_MODE_RST;
            r_part_count <= fpfa_pkg::PART_COUNT_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == fpfa_pkg::REG_FIT_MODE) begin
                r_fit_mode <= i_cfg_data[fpfa_pkg::MODE_W-1:0];
            end else begin
                r_part_count <= i_cfg_data[fpfa_pkg::COUNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_valid <= '0;
            r_rd_live   <= 1'b0;
        end else begin
            if (w_we) begin
                r_mem_valid[w_addr] <= 1'b1;
            end
            r_rd_live <= r_mem_valid[rd_addr];
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_ptr         <= '0;
            r_rdq_ok      <= 1'b0;
            r_rdq_idx     <= '0;
            r_found       <= 1'b0;
            r_chosen      <= '0;
            r_best        <= '0;
            r_size        <= '0;
            r_res_granted <= 1'b0;
            r_res_part    <= '0;
            r_res_left    <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_size   <= i_size_value;
                        r_ptr    <= '0;
                        r_rdq_ok <= 1'b0;
                        r_found  <= 1'b0;
                        r_chosen <= '0;
                        r_best   <= '0;
                        if (i_operation == fpfa_pkg::OP_ALLOC) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_res_granted <= load_ok;
                            r_res_part    <= load_ok ? i_partition_index : '0;
                            r_res_left    <= load_ok ? i_size_value : '0;
                            r_state       <= S_DONE;
                        end
                    end
                end
                S_SCAN: begin
                    // Read one entry per cycle; the entry read last cycle is judged now.
                    if (take) begin
                        r_found  <= 1'b1;
                        r_chosen <= r_rdq_idx;
                        r_best   <= entry;
                    end
                    r_rdq_ok  <= issue;
                    r_rdq_idx <= r_ptr;
                    if (issue) begin
                        r_ptr <= r_ptr + AW'(1);
                    end else begin
                        r_state <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    r_rdq_ok      <= 1'b0;
                    r_res_granted <= r_found;
                    r_res_part    <= r_found ? fpfa_pkg::INDEX_W'(r_chosen) : '0;
                    r_res_left    <= r_found ? new_left : '0;
                    r_state       <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Output register: holds a result until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_out_granted <= 1'b0;
            r_out_part    <= '0;
            r_out_left    <= '0;
        end else if ((r_state == S_DONE) && out_free) begin
            r_out_valid   <= 1'b1;
            r_out_granted <= r_res_granted;
            r_out_part    <= r_res_part;
            r_out_left    <= r_res_left;
        end else if (r_out_valid && !i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_granted          = r_out_granted;
    assign o_partition_number = r_out_part;
    assign o_space_left       = r_out_left;

`ifndef SYNTHESIS
    a_refused_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_granted) |-> ((r_out_part == '0) && (r_out_left == '0)))
        else $error("refused result carries a nonzero partition or size");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_ptr <= active))
        else $error("scan pointer ran past the active partitions");

    a_pick_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> (r_chosen < AW'(PARTS)))
        else $error("chosen partition outside the memory");

    a_update_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE) |=> (r_state == S_DONE))
        else $error("update did not hand its result on");

    a_result_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && out_free) |=> (r_out_valid && (r_state == S_IDLE)))
        else $error("finished result was not loaded into the output register");
`endif

endmodule
